>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL of the scheduler.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, checked outside reset.
`define NRS_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("nrs assertion failed");

// Condition that must never be seen at a clock edge outside reset.
`define NRS_ASSERT_NEVER(name, clk, rst, expr) \
   `NRS_ASSERT(name, clk, rst, !(expr))

`endif

>>> rtl/nrs_pkg.sv
// ----------------------------------------------------------------------------
// nrs_pkg
// Field widths, codes and the board entry type of the scheduler.
// ----------------------------------------------------------------------------
package nrs_pkg;

   localparam int POS_W     = 10;
   localparam int RID_W     = 4;
   localparam int STATUS_W  = 2;
   localparam int CSR_W     = 5;
   localparam int CSR_IDX_W = 1;
   localparam int LAST_W    = 11;

   localparam logic CMD_POST   = 1'b0;
   localparam logic CMD_FINISH = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_POSTED   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_REJECTED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FINISHED = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REQ_COUNT = 1'd1;

   localparam logic [CSR_W-1:0] CAPACITY_RESET  = 5'd16;
   localparam logic [CSR_W-1:0] REQ_COUNT_RESET = 5'd16;

   typedef struct packed {
      logic [RID_W-1:0] requester;
      logic [POS_W-1:0] position;
   } entry_type;

endpackage

>>> rtl/nrs_req_if.sv
// ----------------------------------------------------------------------------
// nrs_req_if
// Request channel: post or finish events with valid/ready handshake.
// ----------------------------------------------------------------------------
interface nrs_req_if import nrs_pkg::*; ();

   logic             valid;
   logic             ready;
   logic             cmd;
   logic [RID_W-1:0] requester_id;
   logic [POS_W-1:0] position;

   modport source (output valid, cmd, requester_id, position, input ready);
   modport sink   (input valid, cmd, requester_id, position, output ready);

endinterface

>>> rtl/nrs_rsp_if.sv
// ----------------------------------------------------------------------------
// nrs_rsp_if
// Response channel: event status and the request served, if any.
// ----------------------------------------------------------------------------
interface nrs_rsp_if import nrs_pkg::*; ();

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic                served_valid;
   logic [RID_W-1:0]    served_requester;
   logic [POS_W-1:0]    served_position;

   modport source (output valid, status, served_valid, served_requester, served_position,
                   input ready);
   modport sink   (input valid, status, served_valid, served_requester, served_position,
                   output ready);

endinterface

>>> rtl/nearest_request_scheduler.sv
// ----------------------------------------------------------------------------
// nearest_request_scheduler
// Board of pending requests served nearest position first.
// ----------------------------------------------------------------------------
// One event is taken at a time. An event with no serve goes from transfer to
// a loaded response through take, check and result. An event that serves
// also scans for the nearest position and closes the gap after the served
// slot between check and result: the board sits in one memory with one read
// and one write port, so the nearest-position scan reads one entry per cycle
// through a single distance/compare unit, and closing the gap moves one
// entry per cycle. The next event is taken while the previous response still
// waits on the rsp side.
// The board needs no clearing after reset; only data from filled slots is
// ever used.
`include "assert_macros.svh"

module nearest_request_scheduler import nrs_pkg::*; #(
   parameter int BOARD_DEPTH    = 16,
   parameter int MAX_REQUESTERS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   nrs_req_if.sink              req_bus,
   nrs_rsp_if.source            rsp_bus,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   localparam int IDX_W  = (BOARD_DEPTH > 1) ? $clog2(BOARD_DEPTH) : 1;
   localparam int CNT_W  = $clog2(BOARD_DEPTH + 1);
   localparam int ACT_W  = $clog2(MAX_REQUESTERS + 1);
   localparam int MAX_CA = (CNT_W > ACT_W) ? CNT_W : ACT_W;
   localparam int CMP_W  = (MAX_CA > CSR_W) ? MAX_CA : CSR_W;
   localparam int ACT_RESET = (int'(REQ_COUNT_RESET) > MAX_REQUESTERS) ?
                              MAX_REQUESTERS : int'(REQ_COUNT_RESET);

   localparam int ST_W = 3;
   localparam logic [ST_W-1:0] ST_IDLE   = 3'd0;
   localparam logic [ST_W-1:0] ST_CHECK  = 3'd1;
   localparam logic [ST_W-1:0] ST_SCAN   = 3'd2;
   localparam logic [ST_W-1:0] ST_SHIFT  = 3'd3;
   localparam logic [ST_W-1:0] ST_RESULT = 3'd4;

   // control state
   logic [ST_W-1:0]          state_ff, state_in;
   logic [CSR_W-1:0]         capacity_ff, capacity_in;
   logic [ACT_W-1:0]         active_ff, active_in;
   logic [CNT_W-1:0]         pending_ff, pending_in;
   logic signed [LAST_W-1:0] last_ff, last_in;
   logic                     rd_vld_ff, rd_vld_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   // working registers
   logic [STATUS_W-1:0]      res_status_ff, res_status_in;
   logic                     res_served_ff, res_served_in;
   logic [CNT_W-1:0]         idx_ff, idx_in;
   logic [CNT_W-1:0]         rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]         best_idx_ff, best_idx_in;
   logic [LAST_W-1:0]        best_dist_ff, best_dist_in;
   entry_type                best_entry_ff, best_entry_in;

   // response registers
   logic [STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic                     rsp_served_ff, rsp_served_in;
   logic [RID_W-1:0]         rsp_requester_ff, rsp_requester_in;
   logic [POS_W-1:0]         rsp_position_ff, rsp_position_in;

   // board memory
   entry_type                board_mem [BOARD_DEPTH];
   entry_type                rd_data_ff;
   logic                     wr_en;
   logic [IDX_W-1:0]         wr_addr;
   entry_type                wr_data;
   logic [IDX_W-1:0]         rd_addr;

   logic [CMP_W-1:0]         cap_ext, depth_ext, cap_eff;
   logic [CMP_W-1:0]         act_ext, thresh, rc_ext, max_ext, act_load;
   logic                     post_ok, serve, more, take_better;
   logic [CNT_W-1:0]         wr_dst;
   logic signed [LAST_W:0]   diff, diff_neg;
   logic [LAST_W-1:0]        seek_dist;
   logic                     req_xfer, shift_end, board_full;

   // single distance/compare unit, with the capacity, serve-threshold and CSR clamp logic
   always_comb begin
      cap_ext   = CMP_W'(capacity_ff);
      depth_ext = CMP_W'(BOARD_DEPTH);
      cap_eff   = (cap_ext > depth_ext) ? depth_ext : cap_ext;
      act_ext   = CMP_W'(active_ff);
      thresh    = (cap_eff < act_ext) ? cap_eff : act_ext;
      serve     = (thresh != '0) && (CMP_W'(pending_ff) >= thresh);
      post_ok   = CMP_W'(pending_ff) < cap_eff;
      rc_ext    = CMP_W'(csr_wdata);
      max_ext   = CMP_W'(MAX_REQUESTERS);
      act_load  = (rc_ext > max_ext) ? max_ext : rc_ext;
      more      = idx_ff < pending_ff;
      wr_dst    = rd_idx_ff - 1'b1;
      diff      = $signed({2'b00, rd_data_ff.position}) - $signed({last_ff[LAST_W-1], last_ff});
      diff_neg  = -diff;
      seek_dist = diff[LAST_W] ? diff_neg[LAST_W-1:0] : diff[LAST_W-1:0];
      take_better = rd_vld_ff && ((rd_idx_ff == '0) || (seek_dist < best_dist_ff));
   end

   // sequencer
   always_comb begin
      state_in         = state_ff;
      capacity_in      = capacity_ff;
      active_in        = active_ff;
      pending_in       = pending_ff;
      last_in          = last_ff;
      rd_vld_in        = 1'b0;
      rsp_valid_in     = rsp_valid_ff;
      res_status_in    = res_status_ff;
      res_served_in    = res_served_ff;
      idx_in           = idx_ff;
      rd_idx_in        = idx_ff;
      best_idx_in      = best_idx_ff;
      best_dist_in     = best_dist_ff;
      best_entry_in    = best_entry_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_served_in    = rsp_served_ff;
      rsp_requester_in = rsp_requester_ff;
      rsp_position_in  = rsp_position_ff;
      wr_en            = 1'b0;
      wr_addr          = pending_ff[IDX_W-1:0];
      wr_data          = '{requester: req_bus.requester_id, position: req_bus.position};
      rd_addr          = idx_ff[IDX_W-1:0];

      if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               if (req_bus.cmd == CMD_POST) begin
                  if (post_ok) begin
                     wr_en         = 1'b1;
                     pending_in    = pending_ff + 1'b1;
                     res_status_in = STATUS_POSTED;
                  end else begin
                     res_status_in = STATUS_REJECTED;
                  end
               end else begin
                  if (active_ff != '0) begin
                     active_in = active_ff - 1'b1;
                  end
                  res_status_in = STATUS_FINISHED;
               end
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            idx_in        = '0;
            res_served_in = serve;
            state_in      = serve ? ST_SCAN : ST_RESULT;
         end
         ST_SCAN: begin
            rd_vld_in = more;
            if (more) begin
               idx_in = idx_ff + 1'b1;
            end
            if (take_better) begin
               best_idx_in   = rd_idx_ff;
               best_dist_in  = seek_dist;
               best_entry_in = rd_data_ff;
            end
            // all entries compared: start closing the gap after the winner
            if (!more && !rd_vld_ff) begin
               idx_in   = best_idx_ff + 1'b1;
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            rd_vld_in = more;
            if (more) begin
               idx_in = idx_ff + 1'b1;
            end
            // move the entry read last cycle down one slot
            if (rd_vld_ff) begin
               wr_en   = 1'b1;
               wr_addr = wr_dst[IDX_W-1:0];
               wr_data = rd_data_ff;
            end
            if (!more && !rd_vld_ff) begin
               pending_in = pending_ff - 1'b1;
               last_in    = $signed({1'b0, best_entry_ff.position});
               state_in   = ST_RESULT;
            end
         end
         ST_RESULT: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in     = 1'b1;
               rsp_status_in    = res_status_ff;
               rsp_served_in    = res_served_ff;
               rsp_requester_in = res_served_ff ? best_entry_ff.requester : '0;
               rsp_position_in  = res_served_ff ? best_entry_ff.position : '0;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_we) begin
         case (csr_index)
            CSR_CAPACITY:  capacity_in = csr_wdata;
            CSR_REQ_COUNT: active_in   = act_load[ACT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         capacity_ff  <= CAPACITY_RESET;
         active_ff    <= ACT_W'(ACT_RESET);
         pending_ff   <= '0;
         last_ff      <= '1;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         capacity_ff  <= capacity_in;
         active_ff    <= active_in;
         pending_ff   <= pending_in;
         last_ff      <= last_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_status_ff    <= res_status_in;
      res_served_ff    <= res_served_in;
      idx_ff           <= idx_in;
      rd_idx_ff        <= rd_idx_in;
      best_idx_ff      <= best_idx_in;
      best_dist_ff     <= best_dist_in;
      best_entry_ff    <= best_entry_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_served_ff    <= rsp_served_in;
      rsp_requester_ff <= rsp_requester_in;
      rsp_position_ff  <= rsp_position_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         board_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= board_mem[rd_addr];
   end

   assign req_bus.ready            = (state_ff == ST_IDLE);
   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.status           = rsp_status_ff;
   assign rsp_bus.served_valid     = rsp_served_ff;
   assign rsp_bus.served_requester = rsp_requester_ff;
   assign rsp_bus.served_position  = rsp_position_ff;

   assign req_xfer   = req_bus.valid && req_bus.ready;
   assign shift_end  = (state_ff == ST_SHIFT) && (state_in == ST_RESULT);
   assign board_full = pending_ff >= CNT_W'(BOARD_DEPTH);

   `NRS_ASSERT(a_pending_bound, clock, reset, pending_ff <= CNT_W'(BOARD_DEPTH))
   `NRS_ASSERT(a_take_to_check, clock, reset, req_xfer |=> (state_ff == ST_CHECK))
   `NRS_ASSERT(a_serve_drop, clock, reset, shift_end |=> (pending_ff == $past(pending_ff) - 1'b1))
   `NRS_ASSERT(a_best_in_range, clock, reset, (state_ff == ST_SHIFT) |-> (best_idx_ff < pending_ff))
   `NRS_ASSERT_NEVER(a_no_post_when_full, clock, reset, wr_en && (state_ff == ST_IDLE) && board_full)

endmodule
